/* design/closest_point_on_segment_assert.svh */
// assertion macros for the closest point on segment block
// used by the port checker only; needs no package
`ifndef CLOSEST_POINT_ON_SEGMENT_ASSERT_SVH
`define CLOSEST_POINT_ON_SEGMENT_ASSERT_SVH

// property checked outside reset
`define CPS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define CPS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/cps_pkg.sv */
// shared types and constants for the closest point on segment block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cps_pkg;

    // width of every coordinate port
    localparam int unsigned PORT_W = 32;

    // entries of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // where the nearest point lies
    typedef enum logic [1:0] {
        WHERE_INSIDE = 2'd0,
        WHERE_A      = 2'd1,
        WHERE_B      = 2'd2
    } where_t;

endpackage

`default_nettype wire

/* design/cps_front.sv */
// front end: accepts a query, forms dot product and squared length, classifies
// depends on cps_pkg
`timescale 1ns / 1ps
`default_nettype none

module cps_front #(
    parameter int unsigned CW = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [cps_pkg::PORT_W-1:0] s_a_x,
    input  wire logic [cps_pkg::PORT_W-1:0] s_a_y,
    input  wire logic [cps_pkg::PORT_W-1:0] s_b_x,
    input  wire logic [cps_pkg::PORT_W-1:0] s_b_y,
    input  wire logic [cps_pkg::PORT_W-1:0] s_p_x,
    input  wire logic [cps_pkg::PORT_W-1:0] s_p_y,
    output logic                          q_push,
    input  wire logic                     q_full,
    output logic [2*CW+2*(CW+1)+2*(2*CW+3)+1:0] q_data
);

    localparam int unsigned EW = CW + 1;
    localparam int unsigned PW = 2 * EW;
    localparam int unsigned SW = PW + 1;

    logic front_en;
    logic v1_reg, v2_reg, v3_reg;

    logic signed [EW-1:0] ax_w, ay_w, bx_w, by_w, px_w, py_w;

    logic signed [CW-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg, ax3_reg, ay3_reg;
    logic signed [EW-1:0] ex1_reg, ey1_reg, fx1_reg, fy1_reg;
    logic signed [EW-1:0] ex2_reg, ey2_reg, ex3_reg, ey3_reg;
    logic signed [PW-1:0] pfx2_reg, pfy2_reg, pex2_reg, pey2_reg;
    logic signed [SW-1:0] d_next, len_next, d3_reg, len3_reg;
    cps_pkg::where_t      code_next, code3_reg;

    // whole front moves together unless the last stage cannot enter the queue
    assign front_en = !v3_reg || !q_full;
    assign s_ready  = front_en;
    assign q_push   = v3_reg && !q_full;

    // low coordinate bits, sign-extended by one bit
    assign ax_w = EW'($signed(s_a_x[CW-1:0]));
    assign ay_w = EW'($signed(s_a_y[CW-1:0]));
    assign bx_w = EW'($signed(s_b_x[CW-1:0]));
    assign by_w = EW'($signed(s_b_y[CW-1:0]));
    assign px_w = EW'($signed(s_p_x[CW-1:0]));
    assign py_w = EW'($signed(s_p_y[CW-1:0]));

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (front_en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // sums and classification
    always_comb begin
        d_next   = SW'(pfx2_reg) + SW'(pfy2_reg);
        len_next = SW'(pex2_reg) + SW'(pey2_reg);
        priority if (d_next <= SW'(0)) begin
            code_next = cps_pkg::WHERE_A;
        end else if (d_next >= len_next) begin
            code_next = cps_pkg::WHERE_B;
        end else begin
            code_next = cps_pkg::WHERE_INSIDE;
        end
    end

    // payload stages: differences, products, sums
    always_ff @(posedge aclk) begin
        if (front_en) begin
            ax1_reg  <= ax_w[CW-1:0];
            ay1_reg  <= ay_w[CW-1:0];
            ex1_reg  <= bx_w - ax_w;
            ey1_reg  <= by_w - ay_w;
            fx1_reg  <= px_w - ax_w;
            fy1_reg  <= py_w - ay_w;

            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            ex2_reg  <= ex1_reg;
            ey2_reg  <= ey1_reg;
            pfx2_reg <= PW'(fx1_reg) * PW'(ex1_reg);
            pfy2_reg <= PW'(fy1_reg) * PW'(ey1_reg);
            pex2_reg <= PW'(ex1_reg) * PW'(ex1_reg);
            pey2_reg <= PW'(ey1_reg) * PW'(ey1_reg);

            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            ex3_reg  <= ex2_reg;
            ey3_reg  <= ey2_reg;
            d3_reg   <= d_next;
            len3_reg <= len_next;
            code3_reg <= code_next;
        end
    end

    assign q_data = {ax3_reg, ay3_reg, ex3_reg, ey3_reg, d3_reg, len3_reg, code3_reg};

endmodule

`default_nettype wire

/* design/cps_fifo.sv */
// short queue between the front end and the divider pipeline
// depends on cps_pkg
`timescale 1ns / 1ps
`default_nettype none

module cps_fifo #(
    parameter int unsigned DW = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire logic [DW-1:0] wr_data,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output logic [DW-1:0]      rd_data
);

    localparam int unsigned PTR_W = $clog2(cps_pkg::QUEUE_DEPTH);

    logic [DW-1:0]    mem_reg [cps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_pop;

    assign full      = count_reg == (PTR_W+1)'(cps_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_pop    = pop && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* design/cps_back.sv */
// back end: pipelined restoring divider for |e|*d/L on both axes, then result select
// depends on cps_pkg
`timescale 1ns / 1ps
`default_nettype none

module cps_back #(
    parameter int unsigned CW = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_pop,
    input  wire logic [2*CW+2*(CW+1)+2*(2*CW+3)+1:0] in_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [cps_pkg::PORT_W-1:0]      m_near_x,
    output logic [cps_pkg::PORT_W-1:0]      m_near_y,
    output logic [1:0]                      m_where_code
);

    localparam int unsigned EW = CW + 1;
    localparam int unsigned MW = EW;
    localparam int unsigned RW = 2 * CW + 3;
    localparam int unsigned NS = 2 * MW;

    logic back_en;

    logic signed [CW-1:0] in_ax, in_ay;
    logic signed [EW-1:0] in_ex, in_ey;
    logic [RW-1:0]        in_d, in_len;
    cps_pkg::where_t      in_code;

    logic [NS:0]                vld_reg;
    logic [NS:0][CW-1:0]        ax_reg, ay_reg;
    logic [NS:0][EW-1:0]        ex_reg, ey_reg;
    logic [NS:0][MW-1:0]        mx_reg, my_reg, qx_reg, qy_reg;
    logic [NS:0][RW-1:0]        d_reg, len_reg, rx_reg, ry_reg;
    cps_pkg::where_t [NS:0]     code_reg;

    logic                       out_valid_reg;
    logic signed [CW-1:0]       nx_next, ny_next, nx_reg, ny_reg;
    logic [1:0]                 where_reg;

    assign {in_ax, in_ay, in_ex, in_ey, in_d, in_len, in_code} = in_data;

    // whole back end moves unless the output register is held
    assign back_en = !out_valid_reg || m_ready;
    assign in_pop  = back_en;

    // valid bits of all stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (back_en) begin
            vld_reg       <= {vld_reg[NS-1:0], in_valid};
            out_valid_reg <= vld_reg[NS];
        end
    end

    // entry stage: magnitudes of the edge vector, cleared remainders
    always_ff @(posedge aclk) begin
        if (back_en) begin
            ax_reg[0]   <= in_ax;
            ay_reg[0]   <= in_ay;
            ex_reg[0]   <= in_ex;
            ey_reg[0]   <= in_ey;
            mx_reg[0]   <= in_ex[EW-1] ? MW'(-in_ex) : MW'(in_ex);
            my_reg[0]   <= in_ey[EW-1] ? MW'(-in_ey) : MW'(in_ey);
            d_reg[0]    <= in_d;
            len_reg[0]  <= in_len;
            code_reg[0] <= in_code;
            rx_reg[0]   <= '0;
            ry_reg[0]   <= '0;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
        end
    end

    // one half step per stage: even stages shift, odd stages add d for a set bit
    for (genvar k = 0; k < NS; k++) begin : g_step
        localparam int unsigned BIT = MW - 1 - k / 2;
        logic [RW-1:0] sx, sy, rx_next, ry_next;
        logic [MW-1:0] qx_next, qy_next;
        logic          gex, gey;

        always_comb begin
            if (k % 2 == 0) begin
                sx = {rx_reg[k][RW-2:0], 1'b0};
                sy = {ry_reg[k][RW-2:0], 1'b0};
            end else begin
                sx = mx_reg[k][BIT] ? rx_reg[k] + d_reg[k] : rx_reg[k];
                sy = my_reg[k][BIT] ? ry_reg[k] + d_reg[k] : ry_reg[k];
            end
            gex     = sx >= len_reg[k];
            gey     = sy >= len_reg[k];
            rx_next = gex ? sx - len_reg[k] : sx;
            ry_next = gey ? sy - len_reg[k] : sy;
            if (k % 2 == 0) begin
                qx_next = {qx_reg[k][MW-2:0], gex};
                qy_next = {qy_reg[k][MW-2:0], gey};
            end else begin
                qx_next = qx_reg[k] + MW'(gex);
                qy_next = qy_reg[k] + MW'(gey);
            end
        end

        always_ff @(posedge aclk) begin
            if (back_en) begin
                ax_reg[k+1]   <= ax_reg[k];
                ay_reg[k+1]   <= ay_reg[k];
                ex_reg[k+1]   <= ex_reg[k];
                ey_reg[k+1]   <= ey_reg[k];
                mx_reg[k+1]   <= mx_reg[k];
                my_reg[k+1]   <= my_reg[k];
                d_reg[k+1]    <= d_reg[k];
                len_reg[k+1]  <= len_reg[k];
                code_reg[k+1] <= code_reg[k];
                rx_reg[k+1]   <= rx_next;
                ry_reg[k+1]   <= ry_next;
                qx_reg[k+1]   <= qx_next;
                qy_reg[k+1]   <= qy_next;
            end
        end
    end

    // result select: endpoint A, endpoint B (A plus edge) or A stepped by the quotient
    always_comb begin
        logic signed [EW-1:0] axw, ayw, exw, eyw, qxw, qyw, sumx, sumy;
        axw = EW'($signed(ax_reg[NS]));
        ayw = EW'($signed(ay_reg[NS]));
        exw = $signed(ex_reg[NS]);
        eyw = $signed(ey_reg[NS]);
        qxw = $signed(qx_reg[NS]);
        qyw = $signed(qy_reg[NS]);
        sumx = '0;
        sumy = '0;
        unique case (code_reg[NS])
            cps_pkg::WHERE_A: begin
                sumx = axw;
                sumy = ayw;
            end
            cps_pkg::WHERE_B: begin
                sumx = axw + exw;
                sumy = ayw + eyw;
            end
            cps_pkg::WHERE_INSIDE: begin
                sumx = exw[EW-1] ? axw - qxw : axw + qxw;
                sumy = eyw[EW-1] ? ayw - qyw : ayw + qyw;
            end
            default: begin
                sumx = axw;
                sumy = ayw;
            end
        endcase
        nx_next = sumx[CW-1:0];
        ny_next = sumy[CW-1:0];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (back_en) begin
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            where_reg <= code_reg[NS];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_near_x     = cps_pkg::PORT_W'(nx_reg);
    assign m_near_y     = cps_pkg::PORT_W'(ny_reg);
    assign m_where_code = where_reg;

endmodule

`default_nettype wire

/* design/closest_point_on_segment.sv */
// throughput: one item per cycle while neither end stalls; the divider is fully pipelined, one half step per stage
// the front stalls only when the four-entry queue is full, the back only on a held result
// reset: synchronous, active low; clears valid bits and queue pointers, no payload
// depends on cps_pkg, cps_front, cps_fifo, cps_back
`timescale 1ns / 1ps
`default_nettype none

module closest_point_on_segment #(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_a_x,
    input  wire logic [31:0] s_a_y,
    input  wire logic [31:0] s_b_x,
    input  wire logic [31:0] s_b_y,
    input  wire logic [31:0] s_p_x,
    input  wire logic [31:0] s_p_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_near_x,
    output logic [31:0]      m_near_y,
    output logic [1:0]       m_where_code
);

    localparam int unsigned QW = 2 * COORD_WIDTH + 2 * (COORD_WIDTH + 1)
                                 + 2 * (2 * COORD_WIDTH + 3) + 2;

    logic          q_push, q_full, q_pop, q_not_empty;
    logic [QW-1:0] q_wr_data, q_rd_data;

    // classification front end
    cps_front #(.CW(COORD_WIDTH)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_a_x   (s_a_x),
        .s_a_y   (s_a_y),
        .s_b_x   (s_b_x),
        .s_b_y   (s_b_y),
        .s_p_x   (s_p_x),
        .s_p_y   (s_p_y),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_data  (q_wr_data)
    );

    // decoupling queue
    cps_fifo #(.DW(QW)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data)
    );

    // divider and result select
    cps_back #(.CW(COORD_WIDTH)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (q_not_empty),
        .in_pop       (q_pop),
        .in_data      (q_rd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_near_x     (m_near_x),
        .m_near_y     (m_near_y),
        .m_where_code (m_where_code)
    );

endmodule

`default_nettype wire

/* design/cps_checker.sv */
// port checker for the closest point on segment block, bound to the top level
// depends on closest_point_on_segment_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "closest_point_on_segment_assert.svh"

module cps_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_near_x,
    input wire logic [31:0] m_near_y,
    input wire logic [1:0]  m_where_code
);

    // a held result keeps its payload
    `CPS_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_near_x) && $stable(m_near_y) && $stable(m_where_code), "result changed while stalled")

    // only the three defined location codes appear
    `CPS_ASSERT(a_code, aclk, aresetn, m_valid |-> m_where_code != 2'd3, "bad where code")

    // reset empties the output side
    `CPS_ASSERT_ALWAYS(a_reset, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind closest_point_on_segment cps_checker u_cps_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_near_x     (m_near_x),
    .m_near_y     (m_near_y),
    .m_where_code (m_where_code)
);

`default_nettype wire
